/* design/angle_cosine_gradient_unit_assert.svh */
// Assertion macros for the checker file.
`ifndef ANGLE_COSINE_GRADIENT_UNIT_ASSERT_SVH
`define ANGLE_COSINE_GRADIENT_UNIT_ASSERT_SVH

// Flag any cycle in which the expression holds.
`define ACG_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// Require the consequent in the same cycle as the antecedent.
`define ACG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* design/acg_pkg.sv */
`default_nettype none
package acg_pkg;

	// Fixed-point format of vectors, lengths and gradients.
	localparam int FRAC_BITS = 22;
	localparam int WORD_WIDTH_DEF = 32;

	// Limb width of the partial products and depth of one multiplier.
	localparam int LIMB_W = 24;
	localparam int MUL_LAT = 4;

	// Depth of one divider lane.
	function automatic int div_lat(input int w);
		return w + 4;
	endfunction

	// Depth of the valid shift line that carries an accepted word to its result strobe.
	function automatic int pipe_depth(input int w);
		return 3 * (MUL_LAT + 1) + div_lat(w) + 2;
	endfunction

endpackage
`default_nettype wire

/* design/acg_delay.sv */
`default_nettype none
module acg_delay #(
	parameter int DW = 1,
	parameter int DEPTH = 1
) (
	input  wire logic          clk,
	input  wire logic [DW-1:0] d,
	output logic      [DW-1:0] q
);

	logic [DW-1:0] sr_q [DEPTH];

	// Advance the shift line one place every cycle.
	always_ff @(posedge clk) begin
		sr_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			sr_q[i] <= sr_q[i-1];
		end
	end

	assign q = sr_q[DEPTH-1];

endmodule
`default_nettype wire

/* design/acg_mul.sv */
`default_nettype none
module acg_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  wire logic                clk,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0]   p
);

	localparam int L  = acg_pkg::LIMB_W;
	localparam int NA = (AW + L - 1) / L;
	localparam int NB = (BW + L - 1) / L;
	localparam int PW = AW + BW;

	logic [AW-1:0]     ua;
	logic [BW-1:0]     ub;
	logic [NA*L-1:0]   ma_s1;
	logic [NB*L-1:0]   mb_s1;
	logic              neg_s1;
	logic [2*L-1:0]    pp_s2 [NA][NB];
	logic              neg_s2;
	logic [PW-1:0]     sum_c;
	logic [PW-1:0]     sum_s3;
	logic              neg_s3;

	// Take magnitudes; the most negative value maps to its unsigned magnitude.
	always_comb begin
		ua = a[AW-1] ? AW'(-a) : AW'(a);
		ub = b[BW-1] ? BW'(-b) : BW'(b);
	end

	// Sum the shifted partial products.
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum_c = sum_c + (PW'(pp_s2[i][j]) << (L * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		ma_s1  <= (NA*L)'(ua);
		mb_s1  <= (NB*L)'(ub);
		neg_s1 <= a[AW-1] ^ b[BW-1];
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s2[i][j] <= ma_s1[i*L +: L] * mb_s1[j*L +: L];
			end
		end
		neg_s2 <= neg_s1;
		sum_s3 <= sum_c;
		neg_s3 <= neg_s2;
		p      <= neg_s3 ? PW'(-sum_s3) : PW'(sum_s3);
	end

endmodule
`default_nettype wire

/* design/acg_div.sv */
`default_nettype none
module acg_div #(
	parameter int WW = 32,
	parameter int NW = 99,
	parameter int DW = 128
) (
	input  wire logic                 clk,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	output logic signed      [WW-1:0] q,
	output logic                      sat
);

	localparam int SH = 2 * acg_pkg::FRAC_BITS + 1;
	localparam int XW = ((NW + SH > DW) ? NW + SH : DW) + 1;
	localparam int YW = DW + 1;
	localparam int CW = (XW > YW + WW) ? XW : YW + WW;

	logic [NW-1:0] mag;
	logic [NW-1:0] mag_s1;
	logic [DW-1:0] den_s1;
	logic          neg_s1;
	logic [CW-1:0] x_s2;
	logic [CW-1:0] y_s2;
	logic          neg_s2;

	logic [CW-1:0] r_q   [WW+1];
	logic [CW-1:0] y_q   [WW+1];
	logic [WW-1:0] qb_q  [WW+1];
	logic          neg_q [WW+1];
	logic          ovf_q [WW+1];

	logic [WW:0]   qq;
	logic [WW:0]   lim;
	logic [WW:0]   qm;
	logic [WW:0]   val;
	logic          sat_c;

	assign mag = num[NW-1] ? NW'(-num) : NW'(num);

	// Form 2*|num|*2^(2F) + den over 2*den, so the floor rounds half away from zero.
	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		den_s1 <= den;
		neg_s1 <= num[NW-1];
		x_s2   <= (CW'(mag_s1) << SH) + CW'(den_s1);
		y_s2   <= CW'(den_s1) << 1;
		neg_s2 <= neg_s1;
		r_q[0]   <= x_s2;
		y_q[0]   <= y_s2;
		qb_q[0]  <= '0;
		neg_q[0] <= neg_s2;
		ovf_q[0] <= x_s2 >= (y_s2 << WW);
	end

	// One quotient bit per stage, most significant first.
	for (genvar n = 1; n <= WW; n++) begin : g_bit
		localparam int K = WW - n;
		logic [CW-1:0] t;
		assign t = y_q[n-1] << K;
		always_ff @(posedge clk) begin
			y_q[n]   <= y_q[n-1];
			neg_q[n] <= neg_q[n-1];
			ovf_q[n] <= ovf_q[n-1];
			if (!ovf_q[n-1] && r_q[n-1] >= t) begin
				r_q[n]  <= r_q[n-1] - t;
				qb_q[n] <= qb_q[n-1] | (WW'(1) << K);
			end else begin
				r_q[n]  <= r_q[n-1];
				qb_q[n] <= qb_q[n-1];
			end
		end
	end

	// Clip the magnitude to the word range and restore the sign.
	always_comb begin
		qq    = ovf_q[WW] ? ((WW+1)'(1) << WW) : {1'b0, qb_q[WW]};
		lim   = neg_q[WW] ? ((WW+1)'(1) << (WW-1)) : (((WW+1)'(1) << (WW-1)) - 1'b1);
		sat_c = qq > lim;
		qm    = sat_c ? lim : qq;
		val   = neg_q[WW] ? ((WW+1)'(0) - qm) : qm;
	end

	always_ff @(posedge clk) begin
		q   <= val[WW-1:0];
		sat <= sat_c;
	end

endmodule
`default_nettype wire

/* design/angle_cosine_gradient_unit.sv */
// Bond-angle cosine gradient in signed fixed point with 22 fraction bits. The unit
// accepts one word per clock whenever start is high; busy is always low. Each word
// passes through input, setup and output registers, three multiplier levels and the
// dividers, which resolve one quotient bit per stage. The done output is high for a
// single cycle with each result; results come back in the order of the words. The
// receiver cannot stall, so it must take every result in the cycle done is high.
`default_nettype none
module angle_cosine_gradient_unit #(
	parameter int WORD_WIDTH = acg_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [WORD_WIDTH-1:0] ji_x,
	input  wire logic signed [WORD_WIDTH-1:0] ji_y,
	input  wire logic signed [WORD_WIDTH-1:0] ji_z,
	input  wire logic        [WORD_WIDTH-2:0] len_ji,
	input  wire logic signed [WORD_WIDTH-1:0] jk_x,
	input  wire logic signed [WORD_WIDTH-1:0] jk_y,
	input  wire logic signed [WORD_WIDTH-1:0] jk_z,
	input  wire logic        [WORD_WIDTH-2:0] len_jk,
	output logic                              done,
	output logic signed      [WORD_WIDTH-1:0] grad_i_x,
	output logic signed      [WORD_WIDTH-1:0] grad_i_y,
	output logic signed      [WORD_WIDTH-1:0] grad_i_z,
	output logic signed      [WORD_WIDTH-1:0] grad_j_x,
	output logic signed      [WORD_WIDTH-1:0] grad_j_y,
	output logic signed      [WORD_WIDTH-1:0] grad_j_z,
	output logic signed      [WORD_WIDTH-1:0] grad_k_x,
	output logic signed      [WORD_WIDTH-1:0] grad_k_y,
	output logic signed      [WORD_WIDTH-1:0] grad_k_z,
	output logic                              zero_length,
	output logic                              saturated
);

	localparam int W     = WORD_WIDTH;
	localparam int ML    = acg_pkg::MUL_LAT;
	localparam int DL    = acg_pkg::div_lat(W);
	localparam int PIPE  = acg_pkg::pipe_depth(W);
	localparam int DW2   = 2 * W + 2;
	localparam int NIW   = 3 * W + 3;
	localparam int NJW   = 5 * W + 5;
	localparam int ZDLY  = 3 * (ML + 1) + DL;
	localparam int PKW   = 6 * NIW + 8 * W;

	logic [PIPE-1:0]         vld_q;

	// Input stage.
	logic [6*W-1:0]          uv_s1;
	logic [W-2:0]            a_s1;
	logic [W-2:0]            b_s1;
	logic                    zl_s1;

	// Level one: dot-product terms and length products.
	logic signed [2*W-1:0]   pr_m1 [3];
	logic signed [2*W-1:0]   a2_m1;
	logic signed [2*W-1:0]   b2_m1;
	logic signed [2*W-1:0]   ab_m1;
	logic signed [DW2-1:0]   d_s2;
	logic [2*W-1:0]          a2_s2;
	logic [2*W-1:0]          b2_s2;
	logic [2*W-1:0]          ab_s2;
	logic [6*W-1:0]          uv_d2;

	// Level two: numerators and single-side denominators.
	logic signed [3*W-1:0]   va2_m2 [3];
	logic signed [3*W+1:0]   ud_m2  [3];
	logic signed [3*W-1:0]   ub2_m2 [3];
	logic signed [3*W+1:0]   vd_m2  [3];
	logic signed [4*W-1:0]   di_m2;
	logic signed [4*W-1:0]   dk_m2;
	logic [2:0][NIW-1:0]     ni_s3;
	logic [2:0][NIW-1:0]     nk_s3;
	logic [4*W-1:0]          di_s3;
	logic [4*W-1:0]          dk_s3;
	logic [4*W-1:0]          l2_d3;

	// Level three: centre-atom numerator and the common denominator.
	logic signed [5*W+2:0]   nib2_m3 [3];
	logic signed [5*W+2:0]   nka2_m3 [3];
	logic signed [6*W-1:0]   dj_m3;
	logic [2:0][NJW-1:0]     nj_s4;
	logic [6*W-1:0]          dj_s4;
	logic [PKW-1:0]          pk_d4;
	logic [2:0][NIW-1:0]     ni_d4;
	logic [2:0][NIW-1:0]     nk_d4;
	logic [4*W-1:0]          di_d4;
	logic [4*W-1:0]          dk_d4;

	// Divider outputs.
	logic signed [W-1:0]     gi_q [3];
	logic signed [W-1:0]     gj_q [3];
	logic signed [W-1:0]     gk_q [3];
	logic [2:0]              si_q;
	logic [2:0]              sj_q;
	logic [2:0]              sk_q;
	logic                    zl_d;

	assign busy = 1'b0;
	assign done = vld_q[PIPE-1];

	// Advance the valid bits with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE-2:0], start};
		end
	end

	// Capture the word.
	always_ff @(posedge clk) begin
		uv_s1 <= {jk_z, jk_y, jk_x, ji_z, ji_y, ji_x};
		a_s1  <= len_ji;
		b_s1  <= len_jk;
		zl_s1 <= (len_ji == '0) || (len_jk == '0);
	end

	for (genvar c = 0; c < 3; c++) begin : g_dot
		acg_mul #(.AW(W), .BW(W)) u_pr (
			.clk (clk),
			.a   ($signed(uv_s1[c*W +: W])),
			.b   ($signed(uv_s1[(c+3)*W +: W])),
			.p   (pr_m1[c])
		);
	end

	acg_mul #(.AW(W), .BW(W)) u_a2 (
		.clk (clk), .a ($signed({1'b0, a_s1})), .b ($signed({1'b0, a_s1})), .p (a2_m1)
	);
	acg_mul #(.AW(W), .BW(W)) u_b2 (
		.clk (clk), .a ($signed({1'b0, b_s1})), .b ($signed({1'b0, b_s1})), .p (b2_m1)
	);
	acg_mul #(.AW(W), .BW(W)) u_ab (
		.clk (clk), .a ($signed({1'b0, a_s1})), .b ($signed({1'b0, b_s1})), .p (ab_m1)
	);

	acg_delay #(.DW(6*W), .DEPTH(ML+1)) u_uv_dly (.clk (clk), .d (uv_s1), .q (uv_d2));

	// Sum the dot product.
	always_ff @(posedge clk) begin
		d_s2  <= DW2'(pr_m1[0]) + DW2'(pr_m1[1]) + DW2'(pr_m1[2]);
		a2_s2 <= a2_m1;
		b2_s2 <= b2_m1;
		ab_s2 <= ab_m1;
	end

	for (genvar c = 0; c < 3; c++) begin : g_num
		acg_mul #(.AW(W), .BW(2*W)) u_va2 (
			.clk (clk), .a ($signed(uv_d2[(c+3)*W +: W])), .b ($signed(a2_s2)),
			.p (va2_m2[c])
		);
		acg_mul #(.AW(W), .BW(DW2)) u_ud (
			.clk (clk), .a ($signed(uv_d2[c*W +: W])), .b (d_s2), .p (ud_m2[c])
		);
		acg_mul #(.AW(W), .BW(2*W)) u_ub2 (
			.clk (clk), .a ($signed(uv_d2[c*W +: W])), .b ($signed(b2_s2)),
			.p (ub2_m2[c])
		);
		acg_mul #(.AW(W), .BW(DW2)) u_vd (
			.clk (clk), .a ($signed(uv_d2[(c+3)*W +: W])), .b (d_s2), .p (vd_m2[c])
		);
	end

	acg_mul #(.AW(2*W), .BW(2*W)) u_di (
		.clk (clk), .a ($signed(a2_s2)), .b ($signed(ab_s2)), .p (di_m2)
	);
	acg_mul #(.AW(2*W), .BW(2*W)) u_dk (
		.clk (clk), .a ($signed(b2_s2)), .b ($signed(ab_s2)), .p (dk_m2)
	);

	acg_delay #(.DW(4*W), .DEPTH(ML+1)) u_l2_dly (
		.clk (clk), .d ({b2_s2, a2_s2}), .q (l2_d3)
	);

	// Form the side numerators.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			ni_s3[c] <= NIW'(va2_m2[c]) - NIW'(ud_m2[c]);
			nk_s3[c] <= NIW'(ub2_m2[c]) - NIW'(vd_m2[c]);
		end
		di_s3 <= di_m2;
		dk_s3 <= dk_m2;
	end

	for (genvar c = 0; c < 3; c++) begin : g_cen
		acg_mul #(.AW(NIW), .BW(2*W)) u_nib2 (
			.clk (clk), .a ($signed(ni_s3[c])), .b ($signed(l2_d3[4*W-1:2*W])),
			.p (nib2_m3[c])
		);
		acg_mul #(.AW(NIW), .BW(2*W)) u_nka2 (
			.clk (clk), .a ($signed(nk_s3[c])), .b ($signed(l2_d3[2*W-1:0])),
			.p (nka2_m3[c])
		);
	end

	acg_mul #(.AW(4*W), .BW(2*W)) u_dj (
		.clk (clk), .a ($signed(di_s3)), .b ($signed(l2_d3[4*W-1:2*W])), .p (dj_m3)
	);

	acg_delay #(.DW(PKW), .DEPTH(ML+1)) u_n_dly (
		.clk (clk), .d ({dk_s3, di_s3, nk_s3, ni_s3}), .q (pk_d4)
	);

	assign {dk_d4, di_d4, nk_d4, ni_d4} = pk_d4;

	// Negate the summed centre-atom numerator.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			nj_s4[c] <= NJW'(-(NJW'(nib2_m3[c]) + NJW'(nka2_m3[c])));
		end
		dj_s4 <= dj_m3;
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		acg_div #(.WW(W), .NW(NIW), .DW(4*W)) u_div_i (
			.clk (clk), .num ($signed(ni_d4[c])), .den (di_d4), .q (gi_q[c]), .sat (si_q[c])
		);
		acg_div #(.WW(W), .NW(NJW), .DW(6*W)) u_div_j (
			.clk (clk), .num ($signed(nj_s4[c])), .den (dj_s4), .q (gj_q[c]), .sat (sj_q[c])
		);
		acg_div #(.WW(W), .NW(NIW), .DW(4*W)) u_div_k (
			.clk (clk), .num ($signed(nk_d4[c])), .den (dk_d4), .q (gk_q[c]), .sat (sk_q[c])
		);
	end

	acg_delay #(.DW(1), .DEPTH(ZDLY)) u_zl_dly (.clk (clk), .d (zl_s1), .q (zl_d));

	// Drop the gradient on a zero length; otherwise register the result word.
	always_ff @(posedge clk) begin
		grad_i_x    <= zl_d ? '0 : gi_q[0];
		grad_i_y    <= zl_d ? '0 : gi_q[1];
		grad_i_z    <= zl_d ? '0 : gi_q[2];
		grad_j_x    <= zl_d ? '0 : gj_q[0];
		grad_j_y    <= zl_d ? '0 : gj_q[1];
		grad_j_z    <= zl_d ? '0 : gj_q[2];
		grad_k_x    <= zl_d ? '0 : gk_q[0];
		grad_k_y    <= zl_d ? '0 : gk_q[1];
		grad_k_z    <= zl_d ? '0 : gk_q[2];
		zero_length <= zl_d;
		saturated   <= !zl_d && (|{si_q, sj_q, sk_q});
	end

endmodule
`default_nettype wire

/* design/acg_checker.sv */
`default_nettype none
`include "angle_cosine_gradient_unit_assert.svh"
module acg_checker #(
	parameter int WORD_WIDTH = acg_pkg::WORD_WIDTH_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic signed [WORD_WIDTH-1:0] grad_i_x,
	input wire logic signed [WORD_WIDTH-1:0] grad_i_y,
	input wire logic signed [WORD_WIDTH-1:0] grad_i_z,
	input wire logic signed [WORD_WIDTH-1:0] grad_j_x,
	input wire logic signed [WORD_WIDTH-1:0] grad_j_y,
	input wire logic signed [WORD_WIDTH-1:0] grad_j_z,
	input wire logic signed [WORD_WIDTH-1:0] grad_k_x,
	input wire logic signed [WORD_WIDTH-1:0] grad_k_y,
	input wire logic signed [WORD_WIDTH-1:0] grad_k_z,
	input wire logic                         zero_length,
	input wire logic                         saturated
);

	localparam int PIPE = acg_pkg::pipe_depth(WORD_WIDTH);

	logic [9*WORD_WIDTH-1:0] all_g;
	logic                    all_zero;
	logic                    any_ext;

	assign all_g = {grad_i_x, grad_i_y, grad_i_z, grad_j_x, grad_j_y, grad_j_z,
		grad_k_x, grad_k_y, grad_k_z};
	assign all_zero = (all_g == '0);

	// Flag a component sitting at either end of the word range.
	always_comb begin
		any_ext = 1'b0;
		for (int c = 0; c < 9; c++) begin
			if (all_g[c*WORD_WIDTH +: WORD_WIDTH] == {1'b0, {(WORD_WIDTH-1){1'b1}}}
					|| all_g[c*WORD_WIDTH +: WORD_WIDTH] == {1'b1, {(WORD_WIDTH-1){1'b0}}}) begin
				any_ext = 1'b1;
			end
		end
	end

	`ACG_ASSERT_NEVER(a_never_busy, busy, "busy raised on a non-stalling pipeline")
	`ACG_ASSERT_IMPL(a_done_latency, done, $past(start, PIPE), "result without a word taken")
	`ACG_ASSERT_IMPL(a_zero_clean, done && zero_length, !saturated && all_zero, "zero length not clean")
	`ACG_ASSERT_IMPL(a_sat_at_rail, done && saturated, any_ext, "saturated with no clipped component")

endmodule

bind angle_cosine_gradient_unit acg_checker #(.WORD_WIDTH(WORD_WIDTH)) u_acg_checker (.*);
`default_nettype wire

/* test/angle_cosine_gradient_unit_tb.sv */
`timescale 1ns / 1ps
module angle_cosine_gradient_unit_tb;

	localparam int W = acg_pkg::WORD_WIDTH_DEF;
	localparam int DRAIN = acg_pkg::pipe_depth(W) + 8;
	localparam int RANDOM_WORDS = 1950;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [W-1:0] u [3];
		logic signed [W-1:0] v [3];
		logic        [W-2:0] la;
		logic        [W-2:0] lb;
	} triplet_t;

	typedef struct {
		logic [W-1:0] g [9];
		logic         zl;
		logic         sat;
	} gradient_t;

	class grad_scoreboard;
		gradient_t pending [$];
		int        n_words;
		int        n_zero;
		int        n_sat;
		int        n_errors;
		string     names [9] = '{"grad_i_x", "grad_i_y", "grad_i_z", "grad_j_x", "grad_j_y",
			"grad_j_z", "grad_k_x", "grad_k_y", "grad_k_z"};

		// round |num| / den * 2^44 to nearest, ties away from zero, then clip
		function automatic logic [W-1:0] round_clip(wide_t num, wide_t den, ref logic sat);
			logic        neg;
			logic [255:0] mag;
			logic [255:0] q;
			logic [255:0] lim;
			logic [W-1:0] r;
			neg = num < 0;
			mag = neg ? -num : num;
			q = ((mag << (2 * acg_pkg::FRAC_BITS + 1)) + den) / (den << 1);
			lim = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
			if (q > lim) begin
				q = lim;
				sat = 1'b1;
			end
			r = q[W-1:0];
			return neg ? -r : r;
		endfunction

		function automatic gradient_t cos_gradient(triplet_t t);
			gradient_t e;
			wide_t     u [3];
			wide_t     v [3];
			wide_t     dot, a, b, a2, b2, den, ni, nk, nj;
			logic      sat;
			sat = 1'b0;
			e.zl = 1'b0;
			if (t.la == 0 || t.lb == 0) begin
				foreach (e.g[c]) e.g[c] = '0;
				e.zl = 1'b1;
				e.sat = 1'b0;
				return e;
			end
			dot = 0;
			for (int c = 0; c < 3; c++) begin
				u[c] = t.u[c];
				v[c] = t.v[c];
				dot += u[c] * v[c];
			end
			a = $signed({225'd0, t.la});
			b = $signed({225'd0, t.lb});
			a2 = a * a;
			b2 = b * b;
			den = a2 * a * b2 * b;
			// exact numerators over the common denominator a^3 b^3
			for (int c = 0; c < 3; c++) begin
				ni = (v[c] * a2 - u[c] * dot) * b2;
				nk = (u[c] * b2 - v[c] * dot) * a2;
				nj = -(ni + nk);
				e.g[c] = round_clip(ni, den, sat);
				e.g[3+c] = round_clip(nj, den, sat);
				e.g[6+c] = round_clip(nk, den, sat);
			end
			e.sat = sat;
			return e;
		endfunction

		function void note_word(triplet_t t);
			gradient_t e;
			e = cos_gradient(t);
			pending.push_back(e);
			n_words++;
			if (e.zl) n_zero++;
			if (e.sat) n_sat++;
		endfunction

		function void check_word(gradient_t got);
			gradient_t e;
			if (pending.size() == 0) begin
				$error("result word with nothing expected");
				n_errors++;
				return;
			end
			e = pending.pop_front();
			foreach (e.g[c]) begin
				if (got.g[c] !== e.g[c]) begin
					$error("%s expected %0d actual %0d", names[c], $signed(e.g[c]),
						$signed(got.g[c]));
					n_errors++;
				end
			end
			if (got.zl !== e.zl) begin
				$error("zero_length expected %0b actual %0b", e.zl, got.zl);
				n_errors++;
			end
			if (got.sat !== e.sat) begin
				$error("saturated expected %0b actual %0b", e.sat, got.sat);
				n_errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                busy_q = 1'b1;
	logic signed [W-1:0] ji_x = '0, ji_y = '0, ji_z = '0;
	logic signed [W-1:0] jk_x = '0, jk_y = '0, jk_z = '0;
	logic        [W-2:0] len_ji = '0, len_jk = '0;
	logic                done;
	logic signed [W-1:0] grad_i_x, grad_i_y, grad_i_z;
	logic signed [W-1:0] grad_j_x, grad_j_y, grad_j_z;
	logic signed [W-1:0] grad_k_x, grad_k_y, grad_k_z;
	logic                zero_length, saturated;
	bit                  idle_on = 1'b1;

	grad_scoreboard sb = new();

	angle_cosine_gradient_unit #(.WORD_WIDTH(W)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.ji_x(ji_x), .ji_y(ji_y), .ji_z(ji_z), .len_ji(len_ji),
		.jk_x(jk_x), .jk_y(jk_y), .jk_z(jk_z), .len_jk(len_jk),
		.done(done),
		.grad_i_x(grad_i_x), .grad_i_y(grad_i_y), .grad_i_z(grad_i_z),
		.grad_j_x(grad_j_x), .grad_j_y(grad_j_y), .grad_j_z(grad_j_z),
		.grad_k_x(grad_k_x), .grad_k_y(grad_k_y), .grad_k_z(grad_k_z),
		.zero_length(zero_length), .saturated(saturated)
	);

	always #4 clk = ~clk;

	// hold busy as the block sees it at the next rising edge
	always @(negedge clk) busy_q <= busy;

	// note every accepted word
	always @(posedge clk) begin
		triplet_t t;
		if (arst_n && start && !busy_q) begin
			t.u = '{ji_x, ji_y, ji_z};
			t.v = '{jk_x, jk_y, jk_z};
			t.la = len_ji;
			t.lb = len_jk;
			sb.note_word(t);
		end
	end

	// check result words mid-cycle, while they are stable
	always @(negedge clk) begin
		gradient_t got;
		if (arst_n && done) begin
			got.g = '{grad_i_x, grad_i_y, grad_i_z, grad_j_x, grad_j_y, grad_j_z,
				grad_k_x, grad_k_y, grad_k_z};
			got.zl = zero_length;
			got.sat = saturated;
			sb.check_word(got);
		end
	end

	// drive one word, after a random gap when gaps are on, and hold it until taken
	task automatic send(triplet_t t);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		ji_x <= t.u[0];
		ji_y <= t.u[1];
		ji_z <= t.u[2];
		len_ji <= t.la;
		jk_x <= t.v[0];
		jk_y <= t.v[1];
		jk_z <= t.v[2];
		len_jk <= t.lb;
		do @(posedge clk); while (busy_q);
	endtask

	function automatic triplet_t make(int su, int sv, int sa, int sb_, int lu, int lv);
		triplet_t t;
		for (int c = 0; c < 3; c++) begin
			t.u[c] = su;
			t.v[c] = sv;
		end
		t.u[1] = lu;
		t.v[2] = lv;
		t.la = (W-1)'(sa);
		t.lb = (W-1)'(sb_);
		return t;
	endfunction

	// random word: mostly vectors with matching lengths, some raw noise, short or zero lengths
	function automatic triplet_t random_triplet();
		triplet_t t;
		int       mode;
		int       span;
		real      s;
		mode = $urandom_range(0, 99);
		span = $urandom_range(8, 28);
		for (int c = 0; c < 3; c++) begin
			t.u[c] = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
			t.v[c] = $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
		end
		s = 0.0;
		for (int c = 0; c < 3; c++) s += real'(t.u[c]) * real'(t.u[c]);
		t.la = (W-1)'($rtoi($sqrt(s)) + $urandom_range(0, 3));
		s = 0.0;
		for (int c = 0; c < 3; c++) s += real'(t.v[c]) * real'(t.v[c]);
		t.lb = (W-1)'($rtoi($sqrt(s)) + $urandom_range(0, 3));
		if (mode < 20) begin
			for (int c = 0; c < 3; c++) begin
				t.u[c] = $urandom;
				t.v[c] = $urandom;
			end
			t.la = (W-1)'($urandom);
			t.lb = (W-1)'($urandom);
		end else if (mode < 25) begin
			t.la = (W-1)'($urandom_range(1, 64));
		end else if (mode < 28) begin
			if ($urandom_range(0, 1)) t.la = '0;
			else t.lb = '0;
		end
		if (t.la == 0 && mode >= 28) t.la = 1;
		if (t.lb == 0 && mode >= 28) t.lb = 1;
		return t;
	endfunction

	initial begin
		triplet_t t;
		int       waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero lengths, unit lengths, full-scale and most negative vectors
		send(make(1 << 22, 1 << 22, 0, 1 << 22, 0, 0));
		send(make(1 << 22, 1 << 22, 1 << 22, 0, 0, 0));
		send(make(-1, -1, 0, 0, 0, 0));
		send(make(32'h7fffffff, 32'h7fffffff, 1, 1, 0, 0));
		send(make(32'h80000000, 32'h80000000, 1, 1, 32'h80000000, 32'h80000000));
		send(make(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0));
		send(make(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff));
		send(make(0, 0, 32'h7fffffff, 1, 0, 0));
		send(make(-1, 1, 32'h7fffffff, 32'h7fffffff, -1, 1));
		// orthogonal unit vectors, then parallel and antiparallel vectors of matching length
		t = make(0, 0, 1 << 22, 1 << 22, 0, 0);
		t.u[0] = 1 << 22;
		t.v[1] = 1 << 22;
		send(t);
		send(make(1 << 22, 1 << 22, 7264748, 7264748, 1 << 22, 1 << 22));
		send(make(1 << 22, -(1 << 22), 7264748, 7264748, 1 << 22, -(1 << 22)));
		// lengths far from the vectors, small enough to clip
		send(make(1 << 20, -(1 << 21), 3, 5, -(1 << 19), 1 << 18));
		send(make(12345, -6789, 1, 32'h7fffffff, 4321, -99));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) idle_on = $urandom_range(0, 3) != 0;
			send(random_triplet());
		end
		start <= 1'b0;

		waited = 0;
		while (sb.pending.size() != 0 && waited < 100 * DRAIN) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d result words never arrived", sb.pending.size());
			sb.n_errors++;
		end

		$display("words sent: %0d, zero-length: %0d, clipped: %0d",
			sb.n_words, sb.n_zero, sb.n_sat);
		if (sb.n_errors == 0) begin
			$display("angle_cosine_gradient_unit verification clean");
		end else begin
			$display("angle_cosine_gradient_unit verification failed");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#5ms;
		$display("angle_cosine_gradient_unit verification failed");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/acg_pkg.sv
design/acg_delay.sv
design/acg_mul.sv
design/acg_div.sv
design/angle_cosine_gradient_unit.sv
design/acg_checker.sv
test/angle_cosine_gradient_unit_tb.sv
